// File: sv/masked_desaturate_tint_pixel_assert.svh
// Assertion macros for the checker module of the pixel block.
`ifndef MASKED_DESATURATE_TINT_PIXEL_ASSERT_SVH
`define MASKED_DESATURATE_TINT_PIXEL_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define MDTP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define MDTP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/mdtp_pkg.sv
// Shared types and constants of the masked desaturate and tint pixel block.
`timescale 1ns / 1ps
`default_nettype none
package mdtp_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SATURATION  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TINT_WEIGHT = 2'd1;

    localparam logic [7:0] SAT_RESET   = 8'd255;
    localparam logic [7:0] TINT_RESET  = 8'd0;
    localparam logic [7:0] FULL_WEIGHT = 8'd255;

    // Luma weights, summing to 256
    localparam logic [15:0] LUMA_R = 16'd79;
    localparam logic [15:0] LUMA_G = 16'd156;
    localparam logic [15:0] LUMA_B = 16'd21;

    typedef struct packed {
        logic       processed;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] back_red;
        logic [7:0] back_green;
        logic [7:0] back_blue;
        logic       last;
    } pix_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       processed;
        logic       last;
    } res_t;

endpackage
`default_nettype wire

// File: sv/mdtp_desat.sv
// Three-stage desaturation pipeline: luma, grey scaling, per-channel mix.
`timescale 1ns / 1ps
`default_nettype none
module mdtp_desat (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [7:0]    saturation,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire mdtp_pkg::pix_t in_pix,
    output logic               out_valid,
    input  wire logic          out_ready,
    output mdtp_pkg::pix_t     out_pix
);
    import mdtp_pkg::*;

    logic        v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next;
    logic        rdy1, rdy2, rdy3;
    pix_t        p1_reg, p2_reg, p3_reg, p3_next;
    logic [15:0] luma_reg, luma_next;
    logic [15:0] grey_reg, grey_next;
    logic [23:0] grey_prod;
    logic [7:0]  inv_sat;
    logic [15:0] mix_r, mix_g, mix_b;

    // A stage takes a word when it is empty or its word moves on
    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign v1_next = rdy1 ? in_valid : v1_reg;
    assign v2_next = rdy2 ? v1_reg : v2_reg;
    assign v3_next = rdy3 ? v2_reg : v3_reg;

    // Stage 1: weighted luma sum
    assign luma_next = 16'(in_pix.red) * LUMA_R + 16'(in_pix.green) * LUMA_G
                     + 16'(in_pix.blue) * LUMA_B;

    // Stage 2: scale luma by the inverse saturation
    assign inv_sat   = FULL_WEIGHT - saturation;
    assign grey_prod = 24'(luma_reg) * 24'(inv_sat);
    assign grey_next = grey_prod[23:8];

    // Stage 3: mix grey into each channel, skip at full saturation
    assign mix_r = 16'(p2_reg.red) * 16'(saturation) + grey_reg;
    assign mix_g = 16'(p2_reg.green) * 16'(saturation) + grey_reg;
    assign mix_b = 16'(p2_reg.blue) * 16'(saturation) + grey_reg;

    always_comb begin
        p3_next = p2_reg;
        if (saturation != FULL_WEIGHT) begin
            p3_next.red   = mix_r[15:8];
            p3_next.green = mix_g[15:8];
            p3_next.blue  = mix_b[15:8];
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Payload, held while the stage is stalled
    always_ff @(posedge aclk) begin
        if (rdy1) begin
            p1_reg   <= in_pix;
            luma_reg <= luma_next;
        end
        if (rdy2) begin
            p2_reg   <= p1_reg;
            grey_reg <= grey_next;
        end
        if (rdy3) begin
            p3_reg <= p3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_pix   = p3_reg;

endmodule
`default_nettype wire

// File: sv/mdtp_tint.sv
// Background blend and pass-through selection into the output register.
`timescale 1ns / 1ps
`default_nettype none
module mdtp_tint (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [7:0]    tint_weight,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire mdtp_pkg::pix_t in_pix,
    output logic               out_valid,
    input  wire logic          out_ready,
    output mdtp_pkg::res_t     out_res
);
    import mdtp_pkg::*;

    logic        v_reg, v_next;
    res_t        res_reg, res_next;
    logic [7:0]  inv_tint;
    logic [15:0] bl_r, bl_g, bl_b;

    assign in_ready = !v_reg || out_ready;
    assign v_next   = in_ready ? in_valid : v_reg;

    // Blend each channel toward the background
    assign inv_tint = FULL_WEIGHT - tint_weight;
    assign bl_r = 16'(in_pix.red) * 16'(inv_tint) + 16'(in_pix.back_red) * 16'(tint_weight);
    assign bl_g = 16'(in_pix.green) * 16'(inv_tint)
                + 16'(in_pix.back_green) * 16'(tint_weight);
    assign bl_b = 16'(in_pix.blue) * 16'(inv_tint)
                + 16'(in_pix.back_blue) * 16'(tint_weight);

    // Select processed colour or background
    always_comb begin
        res_next.processed = in_pix.processed;
        res_next.last      = in_pix.last;
        if (!in_pix.processed) begin
            res_next.red   = in_pix.back_red;
            res_next.green = in_pix.back_green;
            res_next.blue  = in_pix.back_blue;
        end else if (tint_weight == 8'd0) begin
            res_next.red   = in_pix.red;
            res_next.green = in_pix.green;
            res_next.blue  = in_pix.blue;
        end else begin
            res_next.red   = bl_r[15:8];
            res_next.green = bl_g[15:8];
            res_next.blue  = bl_b[15:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else begin
            v_reg <= v_next;
        end
    end

    // Hold the result word while the receiver stalls
    always_ff @(posedge aclk) begin
        if (in_ready) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = v_reg;
    assign out_res   = res_reg;

endmodule
`default_nettype wire

// File: sv/masked_desaturate_tint_pixel.sv
// Top level of the masked desaturate and tint pixel block.
//
// Input channel s_*: one pixel word per handshake (mask byte, icon RGB,
// background RGB, last flag). Output channel m_*: one result word per
// input word, in order, with the resulting RGB, a processed flag and last.
// A zero mask byte processes the icon colour (desaturate, then tint);
// any other mask byte passes the background colour through.
// Each word passes the register stages luma sum, grey scaling, channel mix
// and blend in that order, each with one multiply level. Throughput is one
// pixel per cycle while m_ready is high.
// Every stage has its own valid bit and takes a word when empty or when its
// word moves on, so a stalled receiver fills the pipeline bubbles first and
// s_ready drops only once all four stages hold words; nothing is lost.
// Reset (aresetn low, synchronous) empties the pipeline and sets saturation
// to 255 and tint weight to 0. Write the registers through cfg_we,
// cfg_index and cfg_wdata only while the pipeline is empty.
`timescale 1ns / 1ps
`default_nettype none
module masked_desaturate_tint_pixel (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [mdtp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mdtp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [7:0]                     s_mask_byte,
    input  wire logic [7:0]                     s_icon_red,
    input  wire logic [7:0]                     s_icon_green,
    input  wire logic [7:0]                     s_icon_blue,
    input  wire logic [7:0]                     s_back_red,
    input  wire logic [7:0]                     s_back_green,
    input  wire logic [7:0]                     s_back_blue,
    input  wire logic                           s_last_in,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [7:0]                          m_out_red,
    output logic [7:0]                          m_out_green,
    output logic [7:0]                          m_out_blue,
    output logic                                m_was_processed,
    output logic                                m_last_out
);
    import mdtp_pkg::*;

    logic [7:0] sat_reg, sat_next;
    logic [7:0] tint_reg, tint_next;
    pix_t       in_pix, mid_pix;
    logic       mid_valid, mid_ready;
    res_t       res;

    // Configuration register writes
    always_comb begin
        sat_next  = sat_reg;
        tint_next = tint_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_SATURATION:  sat_next  = cfg_wdata;
                REG_TINT_WEIGHT: tint_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sat_reg  <= SAT_RESET;
            tint_reg <= TINT_RESET;
        end else begin
            sat_reg  <= sat_next;
            tint_reg <= tint_next;
        end
    end

    // Pack the input word
    always_comb begin
        in_pix.processed  = (s_mask_byte == 8'd0);
        in_pix.red        = s_icon_red;
        in_pix.green      = s_icon_green;
        in_pix.blue       = s_icon_blue;
        in_pix.back_red   = s_back_red;
        in_pix.back_green = s_back_green;
        in_pix.back_blue  = s_back_blue;
        in_pix.last       = s_last_in;
    end

    mdtp_desat u_desat (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .saturation (sat_reg),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_pix     (in_pix),
        .out_valid  (mid_valid),
        .out_ready  (mid_ready),
        .out_pix    (mid_pix)
    );

    mdtp_tint u_tint (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tint_weight (tint_reg),
        .in_valid    (mid_valid),
        .in_ready    (mid_ready),
        .in_pix      (mid_pix),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_res     (res)
    );

    assign m_out_red       = res.red;
    assign m_out_green     = res.green;
    assign m_out_blue      = res.blue;
    assign m_was_processed = res.processed;
    assign m_last_out      = res.last;

endmodule
`default_nettype wire

// File: sv/mdtp_checker.sv
// Port-level checker for the pixel block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "masked_desaturate_tint_pixel_assert.svh"
module mdtp_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_out_red,
    input wire logic [7:0] m_out_green,
    input wire logic [7:0] m_out_blue,
    input wire logic       m_was_processed,
    input wire logic       m_last_out
);
    logic [25:0] m_word;

    // Whole result word, for the stability check
    assign m_word = {m_out_red, m_out_green, m_out_blue, m_was_processed, m_last_out};

    // Hold a stalled result word
    `MDTP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `MDTP_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_valid && !m_ready, $stable(m_word))
    // A free receiver lets every stage advance
    `MDTP_ASSERT_NOW(a_ready_chain, aclk, aresetn, m_ready, s_ready)
    // An accepted word reaches the output while the receiver stays ready
    `MDTP_ASSERT_NEXT(a_latency, aclk, aresetn, (s_valid && s_ready) ##1 m_ready ##1 m_ready ##1 m_ready, m_valid)

endmodule

bind masked_desaturate_tint_pixel mdtp_checker u_mdtp_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_out_red       (m_out_red),
    .m_out_green     (m_out_green),
    .m_out_blue      (m_out_blue),
    .m_was_processed (m_was_processed),
    .m_last_out      (m_last_out)
);
`default_nettype wire
